// ===== sv/linear_probe_key_table_top_defines.svh =====
// Assertion macros for the linear probe key table.
`ifndef LINEAR_PROBE_KEY_TABLE_TOP_DEFINES_SVH
`define LINEAR_PROBE_KEY_TABLE_TOP_DEFINES_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define LPKT_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define LPKT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== sv/lpkt_pkg.sv =====
// Types and constants shared by the linear probe key table.
package lpkt_pkg;

   localparam int KEY_W   = 31;
   localparam int ENTRY_W = 6;
   localparam int COUNT_W = 7;
   localparam int HASH_W  = 32;

   localparam logic [1:0] CMD_LOOKUP = 2'd0;
   localparam logic [1:0] CMD_INSERT = 2'd1;
   localparam logic [1:0] CMD_CLEAR  = 2'd2;

   localparam logic [2:0] STATUS_FOUND    = 3'd0;
   localparam logic [2:0] STATUS_INSERTED = 3'd1;
   localparam logic [2:0] STATUS_ABSENT   = 3'd2;
   localparam logic [2:0] STATUS_FULL     = 3'd3;
   localparam logic [2:0] STATUS_CLEARED  = 3'd4;

   localparam logic [ENTRY_W-1:0] MAX_ENTRIES_RESET = 6'd48;

   localparam logic [HASH_W-1:0] HASH_MUL1 = 32'h85EB_CA6B;
   localparam logic [HASH_W-1:0] HASH_MUL2 = 32'hC2B2_AE35;

   typedef struct packed {
      logic [1:0]       cmd;
      logic [KEY_W-1:0] key;
   } req_type;

   typedef struct packed {
      logic [2:0]         status;
      logic [ENTRY_W-1:0] entry_index;
   } rsp_type;

   typedef struct packed {
      logic               used;
      logic [KEY_W-1:0]   key;
      logic [ENTRY_W-1:0] entry;
   } slot_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_HASH1,
      S_HASH2,
      S_HASH3,
      S_MOD,
      S_MOD_FIX,
      S_PROBE,
      S_CLEAR
   } state_type;

endpackage

// ===== sv/linear_probe_key_table_top.sv =====
// Linear probe key table: hashed home slot, linear probing, sequential entry numbers.
//
// One command at a time: start is taken when busy is low, and the result shows on
// rsp_data for one cycle with rsp_valid high; it cannot be held off, so capture it
// then. A lookup or get-or-insert first hashes the key (one shared 32x32 multiplier
// used twice), then, when SLOTS is not a power of two, reduces the hash to a slot
// (the same multiplier gives a reciprocal quotient estimate and then quotient times
// SLOTS, and a last step corrects by one SLOTS), then probes the slots in turn, as
// the slot RAM is read once a cycle; the result follows in the next cycle, when
// busy has dropped and a new command may already be taken. A clear, and the pass
// after reset, write every slot empty one per cycle, busy meanwhile. max_entries is
// to be written through csr_wr_en / csr_wr_data only while the block is idle; the
// block itself does not enforce this.
`include "linear_probe_key_table_top_defines.svh"

module linear_probe_key_table_top #(
   parameter int SLOTS = 64
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  lpkt_pkg::req_type            req_data,
   output logic                         rsp_valid,
   output lpkt_pkg::rsp_type            rsp_data,
   input  logic                         csr_wr_en,
   input  logic [lpkt_pkg::ENTRY_W-1:0] csr_wr_data
);

   localparam int  IDX_W    = $clog2(SLOTS);
   localparam bit  IS_POW2  = (SLOTS == (1 << IDX_W));
   localparam int  SLOT_W   = $bits(lpkt_pkg::slot_type);
   // floor(2^32 / SLOTS); the quotient it gives is at most one short
   localparam logic [63:0] RECIP_FULL = (64'd1 << 32) / 64'(SLOTS);
   localparam logic [lpkt_pkg::HASH_W-1:0] SLOTS_H = lpkt_pkg::HASH_W'(SLOTS);

   lpkt_pkg::state_type state_ff, state_in;

   logic [lpkt_pkg::KEY_W-1:0]   key_ff, key_in;
   logic [1:0]                   cmd_ff, cmd_in;
   logic [lpkt_pkg::HASH_W-1:0]  hash_ff, hash_in;
   logic [lpkt_pkg::HASH_W-1:0]  quo_ff, quo_in;
   logic [IDX_W-1:0]             pos_ff, pos_in;
   logic [IDX_W-1:0]             probe_n_ff, probe_n_in;
   logic [IDX_W-1:0]             clr_addr_ff, clr_addr_in;
   logic                         clr_resp_ff, clr_resp_in;
   logic [lpkt_pkg::COUNT_W-1:0] count_ff, count_in;
   logic [lpkt_pkg::ENTRY_W-1:0] max_ff, max_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   lpkt_pkg::rsp_type            rsp_ff, rsp_in;

   // shared multiplier
   logic [lpkt_pkg::HASH_W-1:0]   mul_a, mul_b;
   logic [2*lpkt_pkg::HASH_W-1:0] mul_full;

   logic [lpkt_pkg::HASH_W-1:0] hash_final;
   logic [lpkt_pkg::HASH_W-1:0] pos_fix;
   logic [IDX_W-1:0]            pos_wrap;
   logic                        room;

   logic [IDX_W-1:0]    ram_raddr, ram_waddr;
   logic                ram_we;
   logic [SLOT_W-1:0]   ram_wdata, ram_rdata;
   lpkt_pkg::slot_type  rd_slot, wr_slot;

   lpkt_ram #(
      .WIDTH (SLOT_W),
      .DEPTH (SLOTS)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign rd_slot   = lpkt_pkg::slot_type'(ram_rdata);
   assign ram_wdata = SLOT_W'(wr_slot);

   assign mul_full   = mul_a * mul_b;
   assign hash_final = hash_ff ^ (hash_ff >> 16);
   assign pos_fix    = (hash_ff >= SLOTS_H) ? hash_ff - SLOTS_H : hash_ff;
   assign pos_wrap   = (pos_ff == IDX_W'(SLOTS - 1)) ? '0 : pos_ff + IDX_W'(1);
   assign room       = (count_ff < {1'b0, max_ff}) &&
                       (32'(count_ff) < 32'(SLOTS));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lpkt_pkg::S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_addr_ff  <= '0;
         clr_resp_ff  <= 1'b0;
         count_ff     <= '0;
         max_ff       <= lpkt_pkg::MAX_ENTRIES_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         clr_addr_ff  <= clr_addr_in;
         clr_resp_ff  <= clr_resp_in;
         count_ff     <= count_in;
         max_ff       <= max_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff     <= key_in;
      cmd_ff     <= cmd_in;
      hash_ff    <= hash_in;
      quo_ff     <= quo_in;
      pos_ff     <= pos_in;
      probe_n_ff <= probe_n_in;
      rsp_ff     <= rsp_in;
   end

   always_comb begin
      state_in     = state_ff;
      key_in       = key_ff;
      cmd_in       = cmd_ff;
      hash_in      = hash_ff;
      quo_in       = quo_ff;
      pos_in       = pos_ff;
      probe_n_in   = probe_n_ff;
      clr_addr_in  = clr_addr_ff;
      clr_resp_in  = clr_resp_ff;
      count_in     = count_ff;
      max_in       = csr_wr_en ? csr_wr_data : max_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      mul_a        = hash_ff;
      mul_b        = lpkt_pkg::HASH_MUL2;
      ram_raddr    = pos_ff;
      ram_we       = 1'b0;
      ram_waddr    = pos_ff;
      wr_slot      = '0;

      case (state_ff)
         lpkt_pkg::S_IDLE: begin
            if (start) begin
               key_in  = req_data.key;
               cmd_in  = req_data.cmd;
               hash_in = {1'b0, req_data.key};
               if (req_data.cmd == lpkt_pkg::CMD_CLEAR) begin
                  count_in    = '0;
                  clr_addr_in = '0;
                  clr_resp_in = 1'b1;
                  state_in    = lpkt_pkg::S_CLEAR;
               end else begin
                  state_in = lpkt_pkg::S_HASH1;
               end
            end
         end

         lpkt_pkg::S_HASH1: begin
            mul_a    = hash_ff ^ (hash_ff >> 16);
            mul_b    = lpkt_pkg::HASH_MUL1;
            hash_in  = mul_full[lpkt_pkg::HASH_W-1:0];
            state_in = lpkt_pkg::S_HASH2;
         end

         lpkt_pkg::S_HASH2: begin
            mul_a    = hash_ff ^ (hash_ff >> 13);
            mul_b    = lpkt_pkg::HASH_MUL2;
            hash_in  = mul_full[lpkt_pkg::HASH_W-1:0];
            state_in = lpkt_pkg::S_HASH3;
         end

         lpkt_pkg::S_HASH3: begin
            hash_in    = hash_final;
            probe_n_in = '0;
            if (IS_POW2) begin
               pos_in    = hash_final[IDX_W-1:0];
               ram_raddr = hash_final[IDX_W-1:0];
               state_in  = lpkt_pkg::S_PROBE;
            end else begin
               mul_a    = hash_final;
               mul_b    = RECIP_FULL[lpkt_pkg::HASH_W-1:0];
               quo_in   = mul_full[2*lpkt_pkg::HASH_W-1:lpkt_pkg::HASH_W];
               state_in = lpkt_pkg::S_MOD;
            end
         end

         // leaves the hash mod SLOTS, plus at most one SLOTS
         lpkt_pkg::S_MOD: begin
            mul_a    = quo_ff;
            mul_b    = SLOTS_H;
            hash_in  = hash_ff - mul_full[lpkt_pkg::HASH_W-1:0];
            state_in = lpkt_pkg::S_MOD_FIX;
         end

         lpkt_pkg::S_MOD_FIX: begin
            pos_in    = pos_fix[IDX_W-1:0];
            ram_raddr = pos_fix[IDX_W-1:0];
            state_in  = lpkt_pkg::S_PROBE;
         end

         // rd_slot holds pos_ff; the next slot is read ahead in case probing goes on
         lpkt_pkg::S_PROBE: begin
            ram_raddr = pos_wrap;
            if (rd_slot.used && rd_slot.key == key_ff) begin
               rsp_valid_in       = 1'b1;
               rsp_in.status      = lpkt_pkg::STATUS_FOUND;
               rsp_in.entry_index = rd_slot.entry;
               state_in           = lpkt_pkg::S_IDLE;
            end else if (!rd_slot.used || probe_n_ff == IDX_W'(SLOTS - 1)) begin
               rsp_valid_in       = 1'b1;
               rsp_in.entry_index = '0;
               state_in           = lpkt_pkg::S_IDLE;
               case (cmd_ff)
                  lpkt_pkg::CMD_INSERT: begin
                     if (!rd_slot.used && room) begin
                        ram_we             = 1'b1;
                        ram_waddr          = pos_ff;
                        wr_slot.used       = 1'b1;
                        wr_slot.key        = key_ff;
                        wr_slot.entry      = count_ff[lpkt_pkg::ENTRY_W-1:0];
                        count_in           = count_ff + lpkt_pkg::COUNT_W'(1);
                        rsp_in.status      = lpkt_pkg::STATUS_INSERTED;
                        rsp_in.entry_index = count_ff[lpkt_pkg::ENTRY_W-1:0];
                     end else begin
                        rsp_in.status = lpkt_pkg::STATUS_FULL;
                     end
                  end
                  default: begin
                     rsp_in.status = lpkt_pkg::STATUS_ABSENT;
                  end
               endcase
            end else begin
               pos_in     = pos_wrap;
               probe_n_in = probe_n_ff + IDX_W'(1);
            end
         end

         lpkt_pkg::S_CLEAR: begin
            ram_we      = 1'b1;
            ram_waddr   = clr_addr_ff;
            clr_addr_in = clr_addr_ff + IDX_W'(1);
            if (clr_addr_ff == IDX_W'(SLOTS - 1)) begin
               state_in    = lpkt_pkg::S_IDLE;
               clr_resp_in = 1'b0;
               if (clr_resp_ff) begin
                  rsp_valid_in       = 1'b1;
                  rsp_in.status      = lpkt_pkg::STATUS_CLEARED;
                  rsp_in.entry_index = '0;
               end
            end
         end

         default: begin
            state_in = lpkt_pkg::S_IDLE;
         end
      endcase
   end

   assign busy      = (state_ff != lpkt_pkg::S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `LPKT_ASSERT_NEXT(a_start_busy, clock, reset, start && !busy, busy,
                     "accepted command did not raise busy")

   `LPKT_ASSERT_SAME(a_rsp_idle, clock, reset, rsp_valid, !busy,
                     "result beat while still busy")

   `LPKT_ASSERT_SAME(a_insert_count, clock, reset,
                     rsp_valid && rsp_data.status == lpkt_pkg::STATUS_INSERTED,
                     count_ff == lpkt_pkg::COUNT_W'(rsp_data.entry_index) + lpkt_pkg::COUNT_W'(1),
                     "inserted entry number out of step with entry count")

   `LPKT_ASSERT_SAME(a_count_limit, clock, reset, 1'b1,
                     count_ff <= lpkt_pkg::COUNT_W'(63),
                     "entry count beyond load limit range")

endmodule

// ===== sv/lpkt_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module lpkt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
